// ----- src/rcsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random charset symbol picker package
// Shared types, register indexes and character tables.
// ----------------------------------------------------------------------------
package rcsp_pkg;

   localparam int WORD_W         = 32;
   localparam int MASK_W         = 4;
   localparam int LEN_W          = 8;
   localparam int CHAR_W         = 7;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 8;
   localparam int DIV_STEPS      = WORD_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
   localparam int MAX_LENGTH_DEF = 255;

   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_MASK      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSWORD_LENGTH = 2'd1;

   localparam logic [MASK_W-1:0] MASK_RESET   = 4'hF;
   localparam logic [LEN_W-1:0]  LENGTH_RESET = 8'd16;

   localparam int CLS_LOWER  = 0;
   localparam int CLS_UPPER  = 1;
   localparam int CLS_DIGIT  = 2;
   localparam int CLS_SYMBOL = 3;

   localparam logic [CHAR_W-1:0] LOWER_N  = 7'd26;
   localparam logic [CHAR_W-1:0] UPPER_N  = 7'd26;
   localparam logic [CHAR_W-1:0] DIGIT_N  = 7'd10;
   localparam logic [CHAR_W-1:0] SYMBOL_N = 7'd27;

   localparam logic [CHAR_W-1:0] LOWER_BASE = 7'h61;
   localparam logic [CHAR_W-1:0] UPPER_BASE = 7'h41;
   localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic div_done;
   } sts_type;

   function automatic logic [CHAR_W-1:0] alpha_size(input logic [MASK_W-1:0] mask);
      logic [CHAR_W-1:0] n;
      n = '0;
      if (mask[CLS_LOWER])  n = n + LOWER_N;
      if (mask[CLS_UPPER])  n = n + UPPER_N;
      if (mask[CLS_DIGIT])  n = n + DIGIT_N;
      if (mask[CLS_SYMBOL]) n = n + SYMBOL_N;
      return n;
   endfunction

   // Remainder of the all-ones word by the alphabet size of each mask.
   function automatic logic [CHAR_W-1:0] full_rem(input logic [MASK_W-1:0] mask);
      logic [CHAR_W-1:0] r;
      unique case (mask)
         4'd0:    r = 7'd0;
         4'd1:    r = 7'd21;
         4'd2:    r = 7'd21;
         4'd3:    r = 7'd47;
         4'd4:    r = 7'd5;
         4'd5:    r = 7'd3;
         4'd6:    r = 7'd3;
         4'd7:    r = 7'd3;
         4'd8:    r = 7'd21;
         4'd9:    r = 7'd41;
         4'd10:   r = 7'd41;
         4'd11:   r = 7'd49;
         4'd12:   r = 7'd6;
         4'd13:   r = 7'd3;
         4'd14:   r = 7'd3;
         default: r = 7'd44;
      endcase
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] reject_limit(input logic [MASK_W-1:0] mask);
      return {WORD_W{1'b1}} - WORD_W'(full_rem(mask));
   endfunction

   function automatic logic [CHAR_W-1:0] symbol_char(input logic [4:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         5'd0:    c = 7'h21;
         5'd1:    c = 7'h23;
         5'd2:    c = 7'h24;
         5'd3:    c = 7'h26;
         5'd4:    c = 7'h28;
         5'd5:    c = 7'h29;
         5'd6:    c = 7'h2A;
         5'd7:    c = 7'h2B;
         5'd8:    c = 7'h2C;
         5'd9:    c = 7'h2D;
         5'd10:   c = 7'h2E;
         5'd11:   c = 7'h2F;
         5'd12:   c = 7'h3A;
         5'd13:   c = 7'h3B;
         5'd14:   c = 7'h3C;
         5'd15:   c = 7'h3D;
         5'd16:   c = 7'h3E;
         5'd17:   c = 7'h3F;
         5'd18:   c = 7'h40;
         5'd19:   c = 7'h5B;
         5'd20:   c = 7'h5C;
         5'd21:   c = 7'h5D;
         5'd22:   c = 7'h5E;
         5'd23:   c = 7'h5F;
         5'd24:   c = 7'h7B;
         5'd25:   c = 7'h7C;
         5'd26:   c = 7'h7D;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char(input logic [MASK_W-1:0] mask,
                                                   input logic [CHAR_W-1:0] idx);
      logic [CHAR_W-1:0] rest;
      logic [CHAR_W-1:0] c;
      logic              hit;
      rest = idx;
      c    = CHAR_NUL;
      hit  = 1'b0;
      if (mask[CLS_LOWER]) begin
         if (rest < LOWER_N) begin
            c   = LOWER_BASE + rest;
            hit = 1'b1;
         end else begin
            rest = rest - LOWER_N;
         end
      end
      if (!hit && mask[CLS_UPPER]) begin
         if (rest < UPPER_N) begin
            c   = UPPER_BASE + rest;
            hit = 1'b1;
         end else begin
            rest = rest - UPPER_N;
         end
      end
      if (!hit && mask[CLS_DIGIT]) begin
         if (rest < DIGIT_N) begin
            c   = DIGIT_BASE + rest;
            hit = 1'b1;
         end else begin
            rest = rest - DIGIT_N;
         end
      end
      if (!hit && mask[CLS_SYMBOL] && (rest < SYMBOL_N)) begin
         c = symbol_char(rest[4:0]);
      end
      return c;
   endfunction

endpackage

// ----- src/rcsp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random charset symbol picker controller
// Sequences accept, bit-serial remainder and result write; owns result valid.
// ----------------------------------------------------------------------------
module rcsp_ctrl
   import rcsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !sts.reject) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (sts.div_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && !sts.reject;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
         end
         ST_WRITE: begin
            cmd.write = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> rsp_valid_ff)
      else $error("written result is not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && rsp_valid_ff) |-> rsp_ready)
      else $error("pending result overwritten");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIVIDE))
      else $error("remainder done outside of divide");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DIVIDE) && !req_ready)
      else $error("load did not start the remainder");

endmodule

// ----- src/rcsp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random charset symbol picker datapath
// Config registers, rejection compare, bit-serial remainder, lookup and count.
// ----------------------------------------------------------------------------
module rcsp_datapath
   import rcsp_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [WORD_W-1:0]     req_random_word,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic [CHAR_W-1:0]     rsp_character,
   output logic                  rsp_last_char
);

   localparam int LEN_CAP = (MAX_LENGTH < 255) ? MAX_LENGTH : 255;
   localparam int CNT_W   = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;

   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic [CHAR_W-1:0]    size_ff, size_in;
   logic [WORD_W-1:0]    limit_ff, limit_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [CHAR_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]     done_ff, done_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;
   logic [CHAR_W:0]      trial;
   logic [LEN_W-1:0]     eff_len;
   logic [LEN_W:0]       done_next;
   logic                 is_last;

   assign sts.reject   = (size_ff != '0) && (req_random_word >= limit_ff);
   assign sts.div_done = (bit_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      mask_in   = mask_ff;
      length_in = length_ff;
      size_in   = size_ff;
      limit_in  = limit_ff;
      if (csr_we && (csr_index == CSR_CLASS_MASK)) begin
         mask_in  = csr_wdata[MASK_W-1:0];
         size_in  = alpha_size(csr_wdata[MASK_W-1:0]);
         limit_in = reject_limit(csr_wdata[MASK_W-1:0]);
      end
      if (csr_we && (csr_index == CSR_PASSWORD_LENGTH)) begin
         length_in = csr_wdata[LEN_W-1:0];
      end
   end

   assign trial = {rem_ff, word_ff[WORD_W-1]};

   always_comb begin
      word_in    = word_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      if (cmd.load) begin
         word_in    = req_random_word;
         rem_in     = '0;
         bit_cnt_in = '0;
      end else if (cmd.step) begin
         word_in    = {word_ff[WORD_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (trial >= {1'b0, size_ff}) begin
            rem_in = CHAR_W'(trial - {1'b0, size_ff});
         end else begin
            rem_in = trial[CHAR_W-1:0];
         end
      end
   end

   always_comb begin
      eff_len = length_ff;
      if (eff_len == '0) eff_len = LEN_W'(1);
      if (eff_len > LEN_W'(LEN_CAP)) eff_len = LEN_W'(LEN_CAP);
      done_next = {1'b0, LEN_W'(done_ff)} + (LEN_W + 1)'(1);
      is_last   = done_next >= {1'b0, eff_len};
   end

   always_comb begin
      done_in = done_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.write) begin
         char_in = pick_char(mask_ff, rem_ff);
         last_in = is_last;
         done_in = is_last ? '0 : CNT_W'(done_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= MASK_RESET;
         length_ff  <= LENGTH_RESET;
         size_ff    <= alpha_size(MASK_RESET);
         limit_ff   <= reject_limit(MASK_RESET);
         bit_cnt_ff <= '0;
         done_ff    <= '0;
      end else begin
         mask_ff    <= mask_in;
         length_ff  <= length_in;
         size_ff    <= size_in;
         limit_ff   <= limit_in;
         bit_cnt_ff <= bit_cnt_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rem_ff  <= rem_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_character = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// ----- src/random_charset_symbol_picker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random charset symbol picker
// Unbiased selection of password characters from enabled classes.
// ----------------------------------------------------------------------------
//  Port group  Direction  Handshake        Payload
//  req_        in         valid / ready    random_word [31:0]
//  rsp_        out        valid / ready    character [6:0], last_char
//  csr_        in         write enable     index [1:0], wdata [7:0]
//
// An accepted word that is kept passes an accept state, 32 steps of the
// bit-serial remainder unit and a state that looks up and registers its character.
// A rejected word is dropped in its accept cycle.
// Reset is synchronous and restores all four classes and length 16.
// The result register holds a character until taken; a new word is accepted
// meanwhile, and its write waits until the register is free.
// ----------------------------------------------------------------------------
module random_charset_symbol_picker
   import rcsp_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_W-1:0]     req_random_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_character,
   output logic                  rsp_last_char,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   rcsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcsp_datapath #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_random_word (req_random_word),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_character   (rsp_character),
      .rsp_last_char   (rsp_last_char)
   );

endmodule

// ----- verif/charset_pick_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character pick checker
// Watches the word, result and register ports of the picker. It predicts the
// character and the end-of-password flag for every kept word taken in, counts
// the dropped ones, and compares each result taken out against the oldest prediction.
// ----------------------------------------------------------------------------
module charset_pick_checker
   import rcsp_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [WORD_W-1:0]     req_random_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CHAR_W-1:0]     rsp_character,
   input  logic                  rsp_last_char,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output int                    chars_checked,
   output int                    words_dropped
);

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_char;
   } picked_char_type;

   logic [MASK_W-1:0] enabled_classes;
   logic [LEN_W-1:0]  pw_length;
   logic [LEN_W-1:0]  pw_position;
   logic [WORD_W-1:0] keep_below;
   string             charset;
   picked_char_type   expected_chars[$];
   picked_char_type   oldest;

   function automatic void rebuild_charset();
      int unsigned n;
      charset = "";
      if (enabled_classes[CLS_LOWER])  charset = {charset, "abcdefghijklmnopqrstuvwxyz"};
      if (enabled_classes[CLS_UPPER])  charset = {charset, "ABCDEFGHIJKLMNOPQRSTUVWXYZ"};
      if (enabled_classes[CLS_DIGIT])  charset = {charset, "0123456789"};
      if (enabled_classes[CLS_SYMBOL]) charset = {charset, "!#$&()*+,-./:;<=>?@[\\]^_{|}"};
      n = charset.len();
      if (n == 0) begin
         keep_below = '1;
      end else begin
         keep_below = 32'hFFFF_FFFF - (32'hFFFF_FFFF % n);
      end
   endfunction

   task automatic predict_pick(input logic [WORD_W-1:0] word);
      int unsigned     n;
      int unsigned     cap;
      picked_char_type pick;
      n = charset.len();
      if (n != 0 && word >= keep_below) begin
         words_dropped++;
         return;
      end
      if (n == 0) begin
         pick.character = CHAR_NUL;
      end else begin
         pick.character = CHAR_W'(charset[int'(word % n)]);
      end
      cap = (pw_length == 0) ? 1 : int'(pw_length);
      if (cap > MAX_LENGTH) cap = MAX_LENGTH;
      pick.last_char = (int'(pw_position) + 1 >= cap);
      pw_position = pick.last_char ? '0 : pw_position + 1'b1;
      expected_chars.push_back(pick);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         enabled_classes = MASK_RESET;
         pw_length       = LENGTH_RESET;
         pw_position     = '0;
         rebuild_charset();
         expected_chars.delete();
         fail_count    = 0;
         chars_checked = 0;
         words_dropped = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               fail_count++;
               $error("character: expected none, got %h", rsp_character);
            end else begin
               oldest = expected_chars.pop_front();
               chars_checked++;
               if (rsp_character !== oldest.character) begin
                  fail_count++;
                  $error("character: expected %h, got %h", oldest.character, rsp_character);
               end
               if (rsp_last_char !== oldest.last_char) begin
                  fail_count++;
                  $error("last_char: expected %b, got %b", oldest.last_char, rsp_last_char);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_pick(req_random_word);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CLASS_MASK: begin
                  enabled_classes = csr_wdata[MASK_W-1:0];
                  rebuild_charset();
               end
               CSR_PASSWORD_LENGTH: begin
                  pw_length = csr_wdata[LEN_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      pending = expected_chars.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random charset symbol picker testbench
// Drives random words and register settings into the picker under several
// idling patterns, while the character pick checker predicts and compares
// every result. Covers all class masks, length extremes and the reject limit.
// ----------------------------------------------------------------------------
module testbench
   import rcsp_pkg::*;
();

   localparam int CYCLE_LIMIT     = 600000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASE_COUNT     = 16;
   localparam int WORDS_PER_PHASE = 70;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [WORD_W-1:0]     req_random_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [CHAR_W-1:0]     rsp_character;
   logic                  rsp_last_char;
   logic                  csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   int fail_count;
   int pending_chars;
   int chars_checked;
   int words_dropped;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int words_sent         = 0;
   int cycle_count        = 0;

   random_charset_symbol_picker DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_character   (rsp_character),
      .rsp_last_char   (rsp_last_char),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   charset_pick_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_character   (rsp_character),
      .rsp_last_char   (rsp_last_char),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending_chars),
      .chars_checked   (chars_checked),
      .words_dropped   (words_dropped)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** random_charset_symbol_picker: FAILED **");
         $finish;
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct    = 74;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 74;
         end
         default: begin
            sender_idle_pct    = 10;
            receiver_stall_pct = 10;
         end
      endcase
   endtask

   task automatic send_word(input logic [WORD_W-1:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_random_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic hold_until_empty();
      req_valid <= 1'b0;
      while (pending_chars != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_chars != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] draw_random_word();
      case ($urandom_range(9))
         0:       return 32'hFFFF_FFFF - $urandom_range(0, 120);
         1:       return $urandom_range(0, 255);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [LEN_W-1:0] length_setting;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);
      @(negedge clock);

      // Reset alphabet of 89 characters: class boundaries and the reject limit.
      send_word(32'd0);
      send_word(32'd25);
      send_word(32'd26);
      send_word(32'd51);
      send_word(32'd52);
      send_word(32'd61);
      send_word(32'd62);
      send_word(32'd88);
      send_word(32'd89);
      send_word(32'hFFFF_FFD2);
      send_word(32'hFFFF_FFD3);
      send_word(32'hFFFF_FFFF);
      drain();

      // With no class enabled every word yields NUL, even the all-ones word.
      write_csr(CSR_CLASS_MASK, 8'h00);
      send_word(32'hFFFF_FFFF);
      send_word(32'd0);
      drain();

      // A length of zero flags every character.
      write_csr(CSR_CLASS_MASK, 8'hF3);
      write_csr(CSR_PASSWORD_LENGTH, 8'd0);
      send_word(32'd7);
      send_word(32'd100);
      drain();

      // Shortening the length below the current count ends the password.
      write_csr(CSR_PASSWORD_LENGTH, 8'd1);
      send_word(32'd3);
      drain();
      write_csr(CSR_PASSWORD_LENGTH, 8'd200);
      repeat (6) send_word($urandom_range(0, 1000));
      drain();
      write_csr(CSR_PASSWORD_LENGTH, 8'd3);
      write_csr(CSR_SPARE_2, 8'hFF);
      write_csr(CSR_SPARE_3, 8'h00);
      send_word(32'd11);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         write_csr(CSR_CLASS_MASK, {4'($urandom_range(15)), MASK_W'(p)});
         case (p)
            0:       length_setting = 8'd1;
            1:       length_setting = 8'd255;
            2:       length_setting = 8'd0;
            15:      length_setting = 8'd200;
            default: length_setting = LEN_W'($urandom_range(2, 40));
         endcase
         write_csr(CSR_PASSWORD_LENGTH, length_setting);
         set_idling(idle_mode_type'(p % 4));
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (p == 9 && i == WORDS_PER_PHASE / 2) hold_until_empty();
            send_word(draw_random_word());
         end
      end
      drain();

      $display("Sent %0d random words over all %0d class masks and lengths 0 to 255.",
               words_sent, PHASE_COUNT);
      $display("Compared %0d characters; %0d words fell at or above the reject limit.",
               chars_checked, words_dropped);
      if (fail_count == 0) begin
         $display("** random_charset_symbol_picker: PASSED **");
      end else begin
         $display("** random_charset_symbol_picker: FAILED **");
      end
      $finish;
   end

endmodule
